// ===== rtl/hashed_page_index_table_top_assert.svh =====
// assertion macros for the hashed page index table
`ifndef HASHED_PAGE_INDEX_TABLE_TOP_ASSERT_SVH
`define HASHED_PAGE_INDEX_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HPIT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define HPIT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hpit_pkg.sv =====
// shared constants and codes of the hashed page index table
`timescale 1ns / 1ps

package hpit_pkg;

	localparam int BUCKET_BITS_DEF = 10;
	localparam int WAYS_DEF        = 4;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = 32;
	localparam int IDXB_W   = 4;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISS    = 2'd3;

	localparam logic [CFG_AW-1:0] REG_MULT  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_ADD   = 2'd1;
	localparam logic [CFG_AW-1:0] REG_INDEX = 2'd2;

	localparam logic [KEY_W-1:0]  MULT_RESET  = 32'd2654435769;
	localparam logic [KEY_W-1:0]  ADD_RESET   = 32'd0;
	localparam logic [IDXB_W-1:0] INDEX_RESET = 4'd10;

endpackage

// ===== rtl/hashed_page_index_table_top.sv =====
// hashed page index table: top level with hash unit, sequencer and storage
//
// Key-to-handle table with a multiplicative hash. Each request word is an
// insert, lookup or delete and gives one response word. Its steps are the hash,
// bucket and fill states, a read and a compare state per slot compared (0 to
// WAYS), the decide state, a move state for a delete that moves the bucket's
// last entry, and the output state; the single slot memory read port and the
// one shared key comparator take the slots one at a time. After reset the
// bucket fill memory is cleared, one bucket a cycle, for all 2^BUCKET_BITS
// buckets (1024 by default), and no request is taken meanwhile. Configuration
// writes are taken at any time but must only be issued while the table is idle.
`timescale 1ns / 1ps
`include "hashed_page_index_table_top_assert.svh"

module hashed_page_index_table_top
	import hpit_pkg::*;
#(
	parameter int BUCKET_BITS = BUCKET_BITS_DEF,
	parameter int WAYS        = WAYS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          kind,
	input  logic signed [KEY_W-1:0] key,
	input  logic [HANDLE_W-1:0] entry_handle,

	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic                hit,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [1:0]          status,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_AW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data
);

	localparam int NBUCKETS = 1 << BUCKET_BITS;
	localparam int NSLOTS   = NBUCKETS * WAYS;
	localparam int SAW      = $clog2(NSLOTS);
	localparam int FW       = $clog2(WAYS + 1);
	localparam int IW       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int HW       = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int SW       = KEY_W + HW;

	typedef enum logic [9:0] {
		S_CLR    = 10'b00_0000_0001,
		S_IDLE   = 10'b00_0000_0010,
		S_HASH   = 10'b00_0000_0100,
		S_BKT    = 10'b00_0000_1000,
		S_FILL   = 10'b00_0001_0000,
		S_RD     = 10'b00_0010_0000,
		S_CMP    = 10'b00_0100_0000,
		S_DECIDE = 10'b00_1000_0000,
		S_MOVE   = 10'b01_0000_0000,
		S_OUT    = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [KEY_W-1:0]       mult_q;
	logic [KEY_W-1:0]       add_q;
	logic [IDXB_W-1:0]      index_bits_q;

	logic [1:0]             kind_q;
	logic [KEY_W-1:0]       key_q;
	logic [HW-1:0]          hnd_q;
	logic [KEY_W-1:0]       h_q;
	logic [BUCKET_BITS-1:0] bucket_q;
	logic [BUCKET_BITS-1:0] clr_q;
	logic [FW-1:0]          fill_q;
	logic [IW-1:0]          idx_q;
	logic [IW-1:0]          pos_q;
	logic                   found_q;
	logic [HW-1:0]          hout_q;

	logic                   res_hit_q;
	logic [HW-1:0]          res_hnd_q;
	logic [1:0]             res_status_q;

	logic                   rsp_valid_q;
	logic                   hit_q;
	logic [HANDLE_W-1:0]    handle_out_q;
	logic [1:0]             status_q;

	logic [KEY_W-1:0]       h_d;
	logic [5:0]             bits_eff;
	logic [5:0]             sh;
	logic [BUCKET_BITS-1:0] bucket_d;
	logic [FW-1:0]          fill_rd;
	logic [FW-1:0]          fill_sat;
	logic [FW-1:0]          fill_m1;
	logic [IW-1:0]          last;
	logic [FW-1:0]          idx_nx;
	logic [KEY_W-1:0]       rd_key;
	logic [HW-1:0]          rd_hnd;
	logic [HANDLE_W-1:0]    res_hnd_ext;
	logic                   rsp_free;
	logic                   req_acc;

	logic                   fill_we;
	logic [BUCKET_BITS-1:0] fill_waddr;
	logic [FW-1:0]          fill_wdata;
	logic [BUCKET_BITS-1:0] fill_raddr;
	logic                   slot_we;
	logic [SAW-1:0]         slot_waddr;
	logic [SW-1:0]          slot_wdata;
	logic [SAW-1:0]         slot_raddr;
	logic [SW-1:0]          slot_rdata;

	function automatic logic [SAW-1:0] slot_addr(input logic [BUCKET_BITS-1:0] b,
			input logic [IW-1:0] i);
		return SAW'(b) * SAW'(WAYS) + SAW'(i);
	endfunction

	// shared hash unit: one multiply-add, then the bucket shift
	assign h_d      = mult_q * key_q + add_q;
	assign bits_eff = (index_bits_q == '0) ? 6'd1 :
			((6'(index_bits_q) > 6'(BUCKET_BITS)) ? 6'(BUCKET_BITS) : 6'(index_bits_q));
	assign sh       = 6'd32 - bits_eff;
	assign bucket_d = BUCKET_BITS'(h_q >> sh);

	assign fill_sat = (fill_rd > FW'(WAYS)) ? FW'(WAYS) : fill_rd;
	assign fill_m1  = fill_q - FW'(1);
	assign last     = fill_m1[IW-1:0];
	assign idx_nx   = FW'(idx_q) + FW'(1);
	assign rd_key   = slot_rdata[SW-1:HW];
	assign rd_hnd   = slot_rdata[HW-1:0];

	always_comb begin
		res_hnd_ext = '0;
		res_hnd_ext[HW-1:0] = res_hnd_q;
	end

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_ready = 1'b1;

	// memory port control
	always_comb begin
		fill_we    = 1'b0;
		fill_waddr = bucket_q;
		fill_wdata = '0;
		fill_raddr = bucket_d;
		slot_we    = 1'b0;
		slot_waddr = slot_addr(bucket_q, pos_q);
		slot_wdata = slot_rdata;
		slot_raddr = slot_addr(bucket_q, idx_q);
		case (state_q)
			S_CLR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
			end
			S_DECIDE: begin
				slot_raddr = slot_addr(bucket_q, last);
				if (kind_q == KIND_INSERT && !found_q && fill_q < FW'(WAYS)) begin
					slot_we    = 1'b1;
					slot_waddr = slot_addr(bucket_q, fill_q[IW-1:0]);
					slot_wdata = {key_q, hnd_q};
					fill_we    = 1'b1;
					fill_wdata = fill_q + FW'(1);
				end else if (kind_q == KIND_DELETE && found_q) begin
					fill_we    = 1'b1;
					fill_wdata = fill_m1;
				end
			end
			S_MOVE: begin
				slot_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q       <= MULT_RESET;
			add_q        <= ADD_RESET;
			index_bits_q <= INDEX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MULT:  mult_q       <= cfg_data;
				REG_ADD:   add_q        <= cfg_data;
				REG_INDEX: index_bits_q <= cfg_data[IDXB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_HASH;
					end
				end
				S_HASH:   state_q <= S_BKT;
				S_BKT:    state_q <= S_FILL;
				S_FILL:   state_q <= (fill_sat == '0) ? S_DECIDE : S_RD;
				S_RD:     state_q <= S_CMP;
				S_CMP: begin
					if (rd_key == key_q || idx_nx >= fill_q) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DECIDE: begin
					if (kind_q == KIND_DELETE && found_q && pos_q != last) begin
						state_q <= S_MOVE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_MOVE:   state_q <= S_OUT;
				S_OUT: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// working registers of the current word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q <= kind;
				key_q  <= key;
				hnd_q  <= entry_handle[HW-1:0];
			end
			S_HASH: h_q <= h_d;
			S_BKT:  bucket_q <= bucket_d;
			S_FILL: begin
				fill_q  <= fill_sat;
				idx_q   <= '0;
				pos_q   <= '0;
				found_q <= 1'b0;
				hout_q  <= '0;
			end
			S_CMP: begin
				if (rd_key == key_q) begin
					found_q <= 1'b1;
					pos_q   <= idx_q;
					hout_q  <= rd_hnd;
				end else begin
					idx_q <= idx_nx[IW-1:0];
				end
			end
			S_DECIDE: begin
				res_hit_q <= found_q;
				res_hnd_q <= hout_q;
				if (kind_q == KIND_INSERT) begin
					if (found_q) begin
						res_status_q <= ST_PRESENT;
					end else if (fill_q >= FW'(WAYS)) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_DONE;
					end
				end else begin
					res_status_q <= found_q ? ST_DONE : ST_MISS;
				end
			end
			default: begin
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_OUT && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && rsp_free) begin
			hit_q        <= res_hit_q;
			handle_out_q <= res_hnd_ext;
			status_q     <= res_status_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign hit        = hit_q;
	assign handle_out = handle_out_q;
	assign status     = status_q;

	hpit_ram #(
		.WIDTH (FW),
		.DEPTH (NBUCKETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rd)
	);

	hpit_ram #(
		.WIDTH (SW),
		.DEPTH (NSLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	`HPIT_ASSERT_NOW(a_clr_stalls, state_q == S_CLR, req_stall, "request taken during clear")
	`HPIT_ASSERT_NEXT(a_acc_hash, req_acc, state_q == S_HASH, "accepted word not hashed")
	`HPIT_ASSERT_NOW(a_rd_nonempty, state_q == S_RD, fill_q != '0, "slot read of empty bucket")
	`HPIT_ASSERT_NOW(a_move_found, state_q == S_MOVE, found_q && kind_q == KIND_DELETE,
		"slot move without a deleted entry")
	`HPIT_ASSERT_NOW(a_full_nohit, rsp_valid && status == ST_FULL, !hit,
		"bucket full reported with a hit")

endmodule

// ===== rtl/hpit_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module hpit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
